### rtl/twmrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package twmrg_pkg;

	// stream codes
	localparam logic STREAM_FWD = 1'b0;
	localparam logic STREAM_REV = 1'b1;

	// what the back end does with a queued item
	typedef enum logic [1:0] {
		KIND_NOP   = 2'd0,  // record or end marker on a closed stream
		KIND_LOAD  = 2'd1,  // record into its stream's head slot
		KIND_CLOSE = 2'd2   // end marker on an open stream
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic       from_rev;
	} item_ctl_t;

	localparam int CTL_W = $bits(item_ctl_t);

endpackage
`default_nettype wire

### rtl/twmrg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module twmrg_front #(
	parameter int REC_W = 322
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     in_from_rev,
	input  wire logic                     in_end,
	input  wire logic [REC_W-1:0]         in_rec,
	output logic                          push,
	output twmrg_pkg::item_ctl_t          push_ctl,
	output logic [REC_W-1:0]              push_rec,
	input  wire logic                     queue_full
);

	logic [1:0] closed_q;
	logic       take;

	assign in_ready = !queue_full;
	assign take     = in_valid && in_ready;
	assign push     = take;
	assign push_rec = in_rec;

	always_comb begin
		push_ctl.from_rev = in_from_rev;
		if (closed_q[in_from_rev]) begin
			push_ctl.kind = twmrg_pkg::KIND_NOP;
		end else if (in_end) begin
			push_ctl.kind = twmrg_pkg::KIND_CLOSE;
		end else begin
			push_ctl.kind = twmrg_pkg::KIND_LOAD;
		end
	end

	// front keeps its own copy of the closed flags to classify items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= '0;
		end else if (take && in_end) begin
			closed_q[in_from_rev] <= 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/twmrg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module twmrg_queue #(
	parameter int W = 325
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              not_empty,
	output logic [W-1:0]      pop_data
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/twmrg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module twmrg_back #(
	parameter int POSITION_WIDTH = 40,
	parameter int NUMBER_WIDTH   = 32,
	parameter int REC_W          = 5 * NUMBER_WIDTH + 4 * POSITION_WIDTH + 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_pop,
	input  wire twmrg_pkg::item_ctl_t item_ctl,
	input  wire logic [REC_W-1:0]     item_rec,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [REC_W-1:0]          out_rec,
	output logic                      out_from_rev,
	output logic                      out_done
);

	localparam int NW    = NUMBER_WIDTH;
	localparam int PW    = POSITION_WIDTH;
	localparam int O_SY  = NW;
	localparam int O_DG  = 2 * NW;
	localparam int O_XS  = O_DG + PW + 1;
	localparam int O_LN  = O_XS + PW;
	localparam int O_YS  = O_LN + PW;
	localparam int O_BK  = O_YS + PW;
	localparam int O_ST  = O_BK + NW;
	localparam int O_SC  = O_ST + 1;
	localparam int KEY_W = 4 * NW + 4 * PW + 2;

	logic [REC_W-1:0] head_q [2];
	logic [1:0]       valid_q;
	logic [1:0]       closed_q;
	logic             m_valid_q;
	logic [REC_W-1:0] m_rec_q;
	logic             m_from_rev_q;
	logic             m_done_q;

	logic [REC_W-1:0] nxt_head [2];
	logic [1:0]       nxt_valid;
	logic [1:0]       nxt_closed;
	logic [KEY_W-1:0] key_f;
	logic [KEY_W-1:0] key_r;
	logic             emit;
	logic             sel;
	logic             done;
	logic             s;

	// signed fields flip their sign bit, strand inverts so forward ranks above
	function automatic logic [KEY_W-1:0] sort_key(input logic [REC_W-1:0] r);
		sort_key = {r[NW-1:0], r[O_SY +: NW], !r[O_XS-1], r[O_DG +: PW],
			r[O_XS +: PW], r[O_LN +: PW], r[O_YS +: PW],
			!r[O_ST-1], r[O_BK +: NW-1], !r[O_ST], r[O_SC +: NW]};
	endfunction

	assign s        = item_ctl.from_rev;
	assign item_pop = item_valid && (!m_valid_q || out_ready);

	always_comb begin
		nxt_head[0] = head_q[0];
		nxt_head[1] = head_q[1];
		nxt_valid   = valid_q;
		nxt_closed  = closed_q;
		case (item_ctl.kind)
			twmrg_pkg::KIND_LOAD: begin
				nxt_head[s]  = item_rec;
				nxt_valid[s] = 1'b1;
			end
			twmrg_pkg::KIND_CLOSE: begin
				nxt_closed[s] = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		key_f = sort_key(nxt_head[0]);
		key_r = sort_key(nxt_head[1]);
		emit  = 1'b0;
		sel   = twmrg_pkg::STREAM_FWD;
		done  = 1'b0;
		if (nxt_valid[0] && nxt_valid[1]) begin
			emit = 1'b1;
			sel  = (key_f >= key_r) ? twmrg_pkg::STREAM_REV : twmrg_pkg::STREAM_FWD;
		end else if (nxt_valid[0] && nxt_closed[1]) begin
			emit = 1'b1;
			sel  = twmrg_pkg::STREAM_FWD;
		end else if (nxt_valid[1] && nxt_closed[0]) begin
			emit = 1'b1;
			sel  = twmrg_pkg::STREAM_REV;
		end else if (nxt_closed == 2'b11 && nxt_valid == 2'b00) begin
			done = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && item_ctl.kind == twmrg_pkg::KIND_LOAD) begin
			head_q[s] <= item_rec;
		end
		if (item_pop) begin
			m_rec_q      <= emit ? nxt_head[sel] : '0;
			m_from_rev_q <= emit && sel;
			m_done_q     <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			closed_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (item_pop) begin
				// the emitted head leaves its slot
				valid_q   <= emit ? (nxt_valid & ~(2'b01 << sel)) : nxt_valid;
				closed_q  <= nxt_closed;
				m_valid_q <= emit || done;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = m_valid_q;
	assign out_rec      = m_rec_q;
	assign out_from_rev = m_from_rev_q;
	assign out_done     = m_done_q;

endmodule
`default_nettype wire

### rtl/two_way_sorted_record_merge_core.sv
// Two-way merge of sorted record streams into one sorted stream.
// Slave channel s_axis_*: one item per record or end marker. tuser[0] picks
// the stream (0 forward, 1 reverse), tuser[1] marks the end of that stream.
// Master channel m_axis_*: the emitted record, or a done item (tuser[1])
// once both streams have ended; tuser[0] names the stream whose next item
// the producer sends. Records compare on seq_x, seq_y, diagonal, x_start,
// length, y_start, block, strand (reverse first) and score; reverse wins ties.
// A front stage classifies each item against the closed flags and pushes
// it into a two-entry queue; the back stage updates the head slots, does
// one wide key compare and loads the output register.
// An accepted item waits in the queue until the back stage pops it.
// Throughput: one item per cycle, limited by the back stage taking one
// queued item per cycle when the output register is free or being taken.
// Reset clears both head slots and reopens both streams. When m_axis_tready
// is low the output register holds; the queue then fills and s_axis_tready
// drops two items later.
`timescale 1ns / 1ps
`default_nettype none
module two_way_sorted_record_merge_core #(
	parameter int POSITION_WIDTH = 40,
	parameter int NUMBER_WIDTH   = 32,
	localparam int REC_W  = 5 * NUMBER_WIDTH + 4 * POSITION_WIDTH + 2,
	localparam int DATA_W = ((REC_W + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// seq_x, seq_y, diagonal, x_start, frag_length, y_start, block_id,
	// strand_reverse, score, payload_tag, zero pad
	input  wire logic [DATA_W-1:0] s_axis_tdata,
	// from_reverse, stream_end
	input  wire logic [1:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// out_seq_x, out_seq_y, out_diagonal, out_x_start, out_length, out_y_start,
	// out_block, out_strand_reverse, out_score, out_tag, zero pad
	output logic [DATA_W-1:0]      m_axis_tdata,
	// out_from_reverse, merge_done
	output logic [1:0]             m_axis_tuser
);

	localparam int Q_W = twmrg_pkg::CTL_W + REC_W;

	logic                 push;
	twmrg_pkg::item_ctl_t push_ctl;
	logic [REC_W-1:0]     push_rec;
	logic                 queue_full;
	logic                 q_pop;
	logic                 q_valid;
	logic [Q_W-1:0]       q_data;
	twmrg_pkg::item_ctl_t q_ctl;
	logic [REC_W-1:0]     q_rec;
	logic [REC_W-1:0]     out_rec;
	logic                 out_from_rev;
	logic                 out_done;

	twmrg_front #(.REC_W(REC_W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_from_rev(s_axis_tuser[0]),
		.in_end     (s_axis_tuser[1]),
		.in_rec     (s_axis_tdata[REC_W-1:0]),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_rec   (push_rec),
		.queue_full (queue_full)
	);

	twmrg_queue #(.W(Q_W)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctl, push_rec}),
		.full     (queue_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.pop_data (q_data)
	);

	assign q_ctl = twmrg_pkg::item_ctl_t'(q_data[Q_W-1:REC_W]);
	assign q_rec = q_data[REC_W-1:0];

	twmrg_back #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.NUMBER_WIDTH  (NUMBER_WIDTH),
		.REC_W         (REC_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (q_valid),
		.item_pop    (q_pop),
		.item_ctl    (q_ctl),
		.item_rec    (q_rec),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_rec     (out_rec),
		.out_from_rev(out_from_rev),
		.out_done    (out_done)
	);

	always_comb begin
		m_axis_tdata              = '0;
		m_axis_tdata[REC_W-1:0]   = out_rec;
		m_axis_tuser              = {out_done, out_from_rev};
	end

endmodule
`default_nettype wire
